### rtl/qou_pkg.sv
// ----------------------------------------------------------------------------
// qou_pkg
// shared types, operation codes and fixed-point constants for the
// quaternion orientation unit
// ----------------------------------------------------------------------------
package qou_pkg;

  localparam int unsigned QOU_WIDTH = 32;
  localparam int unsigned QOU_FRAC  = 28;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_MUL    = 3'd1,
    KIND_ROT    = 3'd2,
    KIND_ADDVEC = 3'd3,
    KIND_NORM   = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] op_r;
    logic signed [31:0] op_i;
    logic signed [31:0] op_j;
    logic signed [31:0] op_k;
    logic signed [31:0] step_scale;
  } qou_in_t;

  typedef struct packed {
    logic signed [31:0] res_r;
    logic signed [31:0] res_i;
    logic signed [31:0] res_j;
    logic signed [31:0] res_k;
    logic               zero_length;
    logic               saturated;
  } qou_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCALE,
    ST_PROD,
    ST_ADDH,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic       capture;
    logic       do_load;
    logic       scale_step;
    logic       prod_step;
    logic       addh;
    logic       sq_step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       commit;
    logic [4:0] idx;
  } qou_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic zero_norm;
    logic sqrt_done;
    logic div_done;
  } qou_sts_t;

  // operand selection of the Hamilton product b = q * p
  // output part n, term t: coefficient q[hq_a(n,t)] * p[t] with sign
  function automatic logic [1:0] hq_a(input logic [1:0] n, input logic [1:0] t);
    logic [1:0] r;
    r = 2'(n ^ t);
    return r;
  endfunction

endpackage

### rtl/qou_ctrl.sv
// ----------------------------------------------------------------------------
// qou_ctrl
// sequencer: steps the shared datapath through one operation per item
// ----------------------------------------------------------------------------
module qou_ctrl import qou_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  logic [2:0] kind,
  input  qou_sts_t sts,
  output qou_cmd_t cmd
);

  state_t     state, state_next;
  logic [4:0] idx, idx_next;
  logic [2:0] kind_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
    if (in_valid && in_ready) kind_q <= kind;
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: if (in_valid) begin
        idx_next = '0;
        unique case (kind)
          KIND_LOAD:   state_next = ST_LOAD;
          KIND_MUL,
          KIND_ROT:    state_next = ST_PROD;
          KIND_ADDVEC: state_next = ST_SCALE;
          KIND_NORM:   state_next = ST_SQ;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_LOAD:  state_next = ST_DONE;
      ST_SCALE: begin
        idx_next = idx + 5'd1;
        if (idx == 5'd2) begin
          idx_next = '0;
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        idx_next = idx + 5'd1;
        if (idx == 5'd15) begin
          idx_next = '0;
          state_next = (kind_q == KIND_ADDVEC) ? ST_ADDH : ST_DONE;
        end
      end
      ST_ADDH: state_next = ST_DONE;
      ST_SQ: begin
        idx_next = idx + 5'd1;
        if (idx == 5'd3) begin
          idx_next = '0;
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sts.zero_norm) state_next = ST_DONE;
        else if (sts.sqrt_done) state_next = ST_DIV;
        idx_next = '0;
      end
      ST_DIV: if (sts.div_done) begin
        idx_next = idx + 5'd1;
        if (idx == 5'd3) state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    unique case (state)
      ST_IDLE:  cmd.capture = in_valid;
      ST_LOAD:  cmd.do_load = 1'b1;
      ST_SCALE: cmd.scale_step = 1'b1;
      ST_PROD:  cmd.prod_step = 1'b1;
      ST_ADDH:  cmd.addh = 1'b1;
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.sqrt_init = (idx == 5'd3);
      end
      ST_SQRT:  begin
        cmd.sqrt_step = 1'b1;
        cmd.div_init = sts.sqrt_done;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_init = sts.div_done && (idx != 5'd3);
      end
      ST_DONE:  cmd.commit = 1'b1;
      default:  ;
    endcase
  end

  a_one_hs: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready and valid together");
  a_out_after_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |=> out_valid) else $error("result not shown");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

### rtl/qou_dp.sv
// ----------------------------------------------------------------------------
// qou_dp
// datapath: state quaternion, shared multiplier with accumulator,
// bit-serial square root and restoring divider
// ----------------------------------------------------------------------------
module qou_dp import qou_pkg::*; #(
  parameter int unsigned WIDTH     = QOU_WIDTH,
  parameter int unsigned FRAC_BITS = QOU_FRAC
) (
  input  logic     clk,
  input  logic     rst,
  input  qou_in_t  in_item,
  input  qou_cmd_t cmd,
  output qou_sts_t sts,
  output qou_out_t out_item
);

  localparam int unsigned PW = 2 * WIDTH;      // product width
  localparam int unsigned AW = PW + 3;         // accumulator width
  localparam int unsigned DW = PW + 2;         // squared norm width
  localparam int unsigned RW = WIDTH + 2;      // root width
  localparam int unsigned NW = WIDTH + FRAC_BITS + 1; // divider numerator
  localparam int unsigned SW = 6;

  localparam logic signed [WIDTH-1:0] SMAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] SMIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic signed [WIDTH-1:0] ONE  = WIDTH'(1) << FRAC_BITS;

  logic signed [WIDTH-1:0] q [4];
  logic signed [WIDTH-1:0] qn [4];
  logic signed [31:0]      op [4];
  logic signed [WIDTH-1:0] v [3];
  logic [2:0]              kind_q;
  logic signed [31:0]      sc;
  logic signed [AW-1:0]    acc;
  logic                    sat_f, zero_f;
  logic [DW-1:0]           dsum;
  logic [DW-1:0]           rem;
  logic [RW-1:0]           root;
  logic [SW-1:0]           scnt;
  logic [NW-1:0]           dnum, drem;
  logic [SW+1:0]           dcnt;
  logic                    dneg;

  function automatic logic signed [WIDTH-1:0] satw(input logic signed [AW-1:0] x,
                                                   output logic s);
    s = 1'b0;
    if (x > AW'(SMAX)) begin s = 1'b1; return SMAX; end
    if (x < AW'(SMIN)) begin s = 1'b1; return SMIN; end
    return x[WIDTH-1:0];
  endfunction

  // one product term per cycle: part = idx[3:2], term = idx[1:0]
  logic [1:0]              pn, pt, ai;
  logic                    neg;
  logic signed [WIDTH-1:0] ma;
  logic signed [31:0]      mb;
  logic signed [PW-1:0]    prod;
  logic signed [AW-1:0]    shifted;
  logic signed [WIDTH-1:0] sres;
  logic                    sres_s;

  assign pn = cmd.idx[3:2];
  assign pt = cmd.idx[1:0];

  always_comb begin
    ai  = hq_a(pn, pt);
    neg = 1'b0;
    // x*y : term t uses x[n^t]*y[t]; sign from Hamilton table
    unique case ({pn, pt})
      4'b0001, 4'b0010, 4'b0011: neg = 1'b1;
      4'b0110: neg = 1'b1;
      4'b1011: neg = 1'b1;
      4'b1101: neg = 1'b1;
      default: neg = 1'b0;
    endcase
    if (kind_q == KIND_ADDVEC) begin
      // (0,v)*q: coefficient is w[n^t] * q[t] with w = (0,v)
      ma = (ai == 2'd0) ? '0 : v[ai - 2'd1];
      mb = 32'(q[pt]);
    end else begin
      ma = q[ai];
      mb = (kind_q == KIND_ROT && pt == 2'd0) ? '0 : op[pt];
    end
    prod = PW'(ma) * PW'(mb);
    shifted = AW'(signed'(acc + (neg ? -AW'(prod) : AW'(prod)))) >>> FRAC_BITS;
  end

  // scale products
  logic signed [PW-1:0] sprod;
  logic signed [AW-1:0] sshift;
  logic signed [WIDTH-1:0] sval;
  logic sval_s;
  assign sprod  = PW'(op[cmd.idx[1:0] + 2'd1]) * PW'(sc);
  assign sshift = AW'(sprod) >>> FRAC_BITS;

  // half-step add and load saturation
  logic signed [WIDTH-1:0] hsum [4];
  logic [3:0] hsat;
  logic signed [WIDTH-1:0] lval [4];
  logic [3:0] lsat;
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      hsum[n] = satw(AW'(q[n]) + (AW'(qn[n]) >>> 1), hsat[n]);
      lval[n] = satw(AW'(op[n]), lsat[n]);
    end
  end

  // squares
  logic signed [PW-1:0] sq;
  assign sq = PW'(q[cmd.idx[1:0]]) * PW'(q[cmd.idx[1:0]]);

  // sqrt step (two bits per cycle)
  logic [DW-1:0] trial;
  assign trial = DW'({root, 2'b01});

  // divider trial; the next part is loaded while the current one is written
  logic [NW-1:0] dtry;
  logic [NW:0]   dsub;
  logic signed [WIDTH-1:0] dsel;
  logic [WIDTH-1:0] dmag;
  assign dsel = q[cmd.div_step ? cmd.idx[1:0] + 2'd1 : cmd.idx[1:0]];
  assign dmag = dsel[WIDTH-1] ? WIDTH'(-dsel) : WIDTH'(dsel);
  assign dtry = {drem[NW-2:0], dnum[NW-1]};
  assign dsub = {1'b0, dtry} - (NW+1)'(root);

  logic [NW-1:0] qmag;
  logic [AW-1:0] qsig;
  logic signed [WIDTH-1:0] dres;
  logic dres_s;
  assign qmag = dnum;
  assign qsig = dneg ? -AW'(qmag) : AW'(qmag);

  always_comb begin
    sres = satw(shifted, sres_s);
    sval = satw(sshift, sval_s);
    dres = satw(signed'(qsig), dres_s);
  end

  assign sts.zero_norm = (dsum == '0);
  assign sts.sqrt_done = (scnt == '0);
  assign sts.div_done  = (dcnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      q[0] <= ONE; q[1] <= '0; q[2] <= '0; q[3] <= '0;
    end else if (cmd.commit && kind_q <= KIND_NORM) begin
      for (int n = 0; n < 4; n++) q[n] <= qn[n];
    end
    if (cmd.capture) begin
      kind_q <= in_item.kind;
      op[0] <= in_item.op_r; op[1] <= in_item.op_i;
      op[2] <= in_item.op_j; op[3] <= in_item.op_k;
      sc <= in_item.step_scale;
      acc <= '0; sat_f <= 1'b0; zero_f <= 1'b0; dsum <= '0;
      for (int n = 0; n < 4; n++) qn[n] <= q[n];
    end
    if (cmd.do_load) begin
      for (int n = 0; n < 4; n++) qn[n] <= lval[n];
      sat_f <= |lsat;
    end
    if (cmd.scale_step) begin
      v[cmd.idx[1:0]] <= sval;
      sat_f <= sat_f | sval_s;
    end
    if (cmd.prod_step) begin
      if (pt == 2'd3) begin
        qn[pn] <= sres;
        sat_f  <= sat_f | sres_s;
        acc    <= '0;
      end else begin
        acc <= acc + (neg ? -AW'(prod) : AW'(prod));
      end
    end
    if (cmd.addh) begin
      for (int n = 0; n < 4; n++) qn[n] <= hsum[n];
      sat_f <= sat_f | (|hsat);
    end
    if (cmd.sq_step) dsum <= dsum + DW'(unsigned'(sq));
    if (cmd.sqrt_init) begin
      rem  <= dsum + DW'(unsigned'(sq));
      root <= '0;
      scnt <= SW'(RW);
    end else if (cmd.sqrt_step && scnt != '0) begin
      scnt <= scnt - SW'(1);
      if ((rem >> (2*(scnt-1))) >= trial) begin
        rem  <= rem - (trial << (2*(scnt-1)));
        root <= {root[RW-2:0], 1'b1};
      end else begin
        root <= {root[RW-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_step && sts.zero_norm) begin
      qn[0] <= ONE; qn[1] <= '0; qn[2] <= '0; qn[3] <= '0;
      zero_f <= 1'b1;
    end
    if (cmd.div_init) begin
      dnum <= NW'(dmag) << FRAC_BITS;
      drem <= '0;
      dneg <= dsel[WIDTH-1];
      dcnt <= (SW+2)'(NW);
    end else if (cmd.div_step && dcnt != '0) begin
      dcnt <= dcnt - (SW+2)'(1);
      if (!dsub[NW]) begin
        drem <= dsub[NW-1:0];
        dnum <= {dnum[NW-2:0], 1'b1};
      end else begin
        drem <= dtry;
        dnum <= {dnum[NW-2:0], 1'b0};
      end
    end
    if (cmd.div_step && sts.div_done) begin
      qn[cmd.idx[1:0]] <= dres;
      sat_f <= sat_f | dres_s;
    end
  end

  assign out_item.res_r = 32'(q[0]);
  assign out_item.res_i = 32'(q[1]);
  assign out_item.res_j = 32'(q[2]);
  assign out_item.res_k = 32'(q[3]);
  assign out_item.zero_length = zero_f;
  assign out_item.saturated   = sat_f;

endmodule

### rtl/quaternion_orientation_unit_core.sv
// ----------------------------------------------------------------------------
// quaternion_orientation_unit_core
// one item per operation: load, multiply, rotate, integrate, normalize
// ----------------------------------------------------------------------------
// steps per kind: load goes through LOAD; multiply and rotate through PROD;
//   add scaled vector through SCALE, PROD and ADDH; normalize through SQ, SQRT
//   and DIV, or SQ and SQRT only when all zero; unused kinds go straight to DONE
// throughput: one item at a time, set by the shared multiplier sequence and the
//   bit-serial square root and divider; next item waits for the result accept
// reset: synchronous; stored quaternion returns to identity (1,0,0,0)
module quaternion_orientation_unit_core import qou_pkg::*; #(
  parameter int unsigned WIDTH     = QOU_WIDTH,
  parameter int unsigned FRAC_BITS = QOU_FRAC
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  qou_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output qou_out_t out_data
);

  // command and status between sequencer and datapath
  qou_cmd_t cmd;
  qou_sts_t sts;

  qou_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .kind(in_data.kind), .sts, .cmd
  );

  qou_dp #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .in_item(in_data), .cmd, .sts, .out_item(out_data)
  );

endmodule

### dv/tb_quaternion_orientation_unit_core.sv
// ----------------------------------------------------------------------------
// tb_quaternion_orientation_unit_core
// drives load, multiply, rotate, integrate and normalize items through the
// core and checks every result against an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module tb_quaternion_orientation_unit_core;
  import qou_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     N_RANDOM    = 1330;
  localparam int     CYCLE_LIMIT = 3000000;
  localparam longint QMAX        = 64'sd2147483647;
  localparam longint QMIN        = -64'sd2147483648;
  localparam longint ONE_Q       = 64'sd1 << QOU_FRAC;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  qou_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qou_out_t out_data;

  quaternion_orientation_unit_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state: the stored orientation quaternion
  longint   orient_q [4];
  bit       clip_seen;
  qou_out_t expected_results [$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       quiet_phase = 1'b0;   // no idling on either side
  bit       hold_off = 1'b0;      // receiver stalls for a long stretch

  function automatic longint clip(input longint v);
    if (v > QMAX) begin
      clip_seen = 1'b1;
      return QMAX;
    end
    if (v < QMIN) begin
      clip_seen = 1'b1;
      return QMIN;
    end
    return v;
  endfunction

  // exact four-term sum, floor shift by the fraction bits, then clip
  function automatic longint frac_sum(input longint t0, t1, t2, t3);
    logic signed [127:0] acc;
    acc = 128'(t0) + 128'(t1) + 128'(t2) + 128'(t3);
    acc = acc >>> QOU_FRAC;
    if (acc > 128'(QMAX)) return clip(QMAX + 1);
    if (acc < 128'(QMIN)) return clip(QMIN - 1);
    return longint'(acc);
  endfunction

  function automatic void right_multiply(input longint r, i, j, k);
    longint a, b, c, d;
    a = orient_q[0]; b = orient_q[1]; c = orient_q[2]; d = orient_q[3];
    orient_q[0] = frac_sum(a * r, -(b * i), -(c * j), -(d * k));
    orient_q[1] = frac_sum(a * i, b * r, c * k, -(d * j));
    orient_q[2] = frac_sum(a * j, c * r, d * i, -(b * k));
    orient_q[3] = frac_sum(a * k, d * r, b * j, -(c * i));
  endfunction

  function automatic longint int_sqrt(input logic [63:0] n);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(root);
  endfunction

  // works out the next state and the result for one accepted item
  function automatic qou_out_t predict_orientation(input qou_in_t it);
    qou_out_t    res;
    longint      vx, vy, vz, sc, a, b, c, pr, pi, pj, pk, s;
    logic [64:0] dsum;
    bit          zero;
    vx = it.op_i; vy = it.op_j; vz = it.op_k; sc = it.step_scale;
    zero = 1'b0;
    clip_seen = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        orient_q[0] = it.op_r; orient_q[1] = vx;
        orient_q[2] = vy;      orient_q[3] = vz;
      end
      KIND_MUL: right_multiply(longint'(it.op_r), vx, vy, vz);
      KIND_ROT: right_multiply(0, vx, vy, vz);
      KIND_ADDVEC: begin
        a  = clip((vx * sc) >>> QOU_FRAC);
        b  = clip((vy * sc) >>> QOU_FRAC);
        c  = clip((vz * sc) >>> QOU_FRAC);
        pr = frac_sum(-(a * orient_q[1]), -(b * orient_q[2]), -(c * orient_q[3]), 0);
        pi = frac_sum(a * orient_q[0], b * orient_q[3], -(c * orient_q[2]), 0);
        pj = frac_sum(b * orient_q[0], c * orient_q[1], -(a * orient_q[3]), 0);
        pk = frac_sum(c * orient_q[0], a * orient_q[2], -(b * orient_q[1]), 0);
        orient_q[0] = clip(orient_q[0] + (pr >>> 1));
        orient_q[1] = clip(orient_q[1] + (pi >>> 1));
        orient_q[2] = clip(orient_q[2] + (pj >>> 1));
        orient_q[3] = clip(orient_q[3] + (pk >>> 1));
      end
      KIND_NORM: begin
        dsum = '0;
        for (int n = 0; n < 4; n++) dsum += 65'(orient_q[n] * orient_q[n]);
        if (dsum == 0) begin
          zero = 1'b1;
          orient_q[0] = ONE_Q;
          orient_q[1] = 0; orient_q[2] = 0; orient_q[3] = 0;
        end else begin
          // a 64-bit overflow of the squared norm clamps the root to 2^32
          s = dsum[64] ? (64'sd1 <<< 32) : int_sqrt(dsum[63:0]);
          for (int n = 0; n < 4; n++)
            orient_q[n] = clip((orient_q[n] * ONE_Q) / s);
        end
      end
      default: ;
    endcase
    res.res_r = orient_q[0][31:0];
    res.res_i = orient_q[1][31:0];
    res.res_j = orient_q[2][31:0];
    res.res_k = orient_q[3][31:0];
    res.zero_length = zero;
    res.saturated = clip_seen;
    return res;
  endfunction

  // directed table: kind, operands, and a typed-in result where obvious
  typedef struct {
    qou_in_t  item;
    bit       has_fixed;
    qou_out_t fixed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic qou_in_t mk(input logic [2:0] k, input logic [31:0] r, i, j, q,
                                 input logic [31:0] sc);
    qou_in_t it;
    it.kind = k; it.op_r = r; it.op_i = i; it.op_j = j; it.op_k = q;
    it.step_scale = sc;
    return it;
  endfunction

  function automatic qou_out_t mo(input logic [31:0] r, i, j, q, input bit z, s);
    qou_out_t o;
    o.res_r = r; o.res_i = i; o.res_j = j; o.res_k = q;
    o.zero_length = z; o.saturated = s;
    return o;
  endfunction

  task automatic add_row(input qou_in_t it, input bit fx, input qou_out_t o);
    dir_row_t row;
    row.item = it; row.has_fixed = fx; row.fixed = o;
    dir_rows.push_back(row);
  endtask

  initial begin
    qou_out_t nofix;
    nofix = '0;
    // normalize right after reset keeps the identity
    add_row(mk(KIND_NORM, 0, 0, 0, 0, 0), 1, mo(32'h1000_0000, 0, 0, 0, 0, 0));
    // rotate of identity by a vector gives the pure quaternion
    add_row(mk(KIND_ROT, 32'h7fff_ffff, 32'h1000_0000, 32'hf000_0000, 32'h0800_0000, 0),
            1, mo(0, 32'h1000_0000, 32'hf000_0000, 32'h0800_0000, 0, 0));
    add_row(mk(KIND_LOAD, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0),
            1, mo(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0, 0));
    add_row(mk(KIND_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0),
            0, nofix);
    add_row(mk(KIND_NORM, 0, 0, 0, 0, 0), 0, nofix);
    // all-zero quaternion normalizes to identity with the zero flag
    add_row(mk(KIND_LOAD, 0, 0, 0, 0, 32'hffff_ffff), 1, mo(0, 0, 0, 0, 0, 0));
    add_row(mk(KIND_NORM, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               32'hffff_ffff), 1, mo(32'h1000_0000, 0, 0, 0, 1, 0));
    add_row(mk(KIND_ADDVEC, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
               32'h8000_0000), 0, nofix);
    add_row(mk(KIND_ADDVEC, 0, 32'h1000_0000, 32'h2000_0000, 32'hf000_0000,
               32'h0100_0000), 0, nofix);
    add_row(mk(KIND_ROT, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0), 0, nofix);
    // unused kinds leave the state and clear both flags
    add_row(mk(3'd5, 32'h1234_5678, 1, 2, 3, 4), 0, nofix);
    add_row(mk(3'd6, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
               32'hffff_ffff), 0, nofix);
    add_row(mk(3'd7, 0, 0, 0, 0, 0), 0, nofix);
    add_row(mk(KIND_LOAD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0),
            1, mo(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0));
    // squared norm overflows 64 bits
    add_row(mk(KIND_NORM, 0, 0, 0, 0, 0), 0, nofix);
    add_row(mk(KIND_LOAD, 1, 0, 0, 0, 0), 1, mo(1, 0, 0, 0, 0, 0));
    add_row(mk(KIND_NORM, 0, 0, 0, 0, 0), 0, nofix);
    add_row(mk(KIND_MUL, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 32'h1000_0000, 0),
            0, nofix);
  end

  // random item, mostly plausible orientations with some full-range noise
  function automatic logic [31:0] rand_part(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic qou_in_t rand_item();
    qou_in_t it;
    int      mode, pick;
    pick = $urandom_range(0, 99);
    mode = (pick < 15) ? 0 : (pick < 80) ? 1 : (pick < 85) ? 2 : 3;
    pick = $urandom_range(0, 99);
    if (pick < 12)      it.kind = KIND_LOAD;
    else if (pick < 32) it.kind = KIND_MUL;
    else if (pick < 50) it.kind = KIND_ROT;
    else if (pick < 72) it.kind = KIND_ADDVEC;
    else if (pick < 96) it.kind = KIND_NORM;
    else                it.kind = 3'($urandom_range(5, 7));
    it.op_r = rand_part(mode);
    it.op_i = rand_part(mode);
    it.op_j = rand_part(mode);
    it.op_k = rand_part(mode);
    it.step_scale = rand_part($urandom_range(0, 3));
    if (it.kind == KIND_LOAD && $urandom_range(0, 19) == 0) begin
      it.op_r = 0; it.op_i = 0; it.op_j = 0; it.op_k = 0;
    end
    return it;
  endfunction

  // offers one item at the falling edge and holds it until accepted;
  // valid only drops when the sender idles before the next item
  task automatic send_item(input qou_in_t it);
    while (!quiet_phase && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // fixed expectations from the table, checked on top of the predictor
  qou_out_t table_expect [$];
  bit       table_has [$];

  // expectations are recorded at the accepting edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) expected_results.push_back(predict_orientation(in_data));
  end

  // result checker
  always @(posedge clk) begin
    qou_out_t want;
    qou_out_t fixed;
    bit       fx;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %p", out_data);
      end else begin
        want = expected_results.pop_front();
        fx = 1'b0;
        if (table_has.size() != 0) begin
          fx = table_has.pop_front();
          fixed = table_expect.pop_front();
        end
        if (out_data !== want || (fx && out_data !== fixed)) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %p (table %0d %p) got %p",
                     want, fx, fixed, out_data);
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, and a quiet stretch
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if (quiet_phase) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 28);
  end

  // the long hold-off is counted here in cycles
  initial begin
    wait (!rst);
    repeat (3000) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (600) @(negedge clk);
    hold_off = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_quaternion_orientation_unit_core: errors");
      $finish;
    end
  end

  initial begin
    orient_q[0] = ONE_Q;
    orient_q[1] = 0; orient_q[2] = 0; orient_q[3] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed part
    foreach (dir_rows[n]) begin
      table_has.push_back(dir_rows[n].has_fixed);
      table_expect.push_back(dir_rows[n].fixed);
      send_item(dir_rows[n].item);
    end
    // random part, with a quiet stretch in the middle
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet_phase = (n >= 600 && n < 750);
      send_item(rand_item());
    end
    in_valid <= 1'b0;
    quiet_phase = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("tb_quaternion_orientation_unit_core: clean");
    end else begin
      $display("tb_quaternion_orientation_unit_core: errors");
    end
    $finish;
  end

endmodule
